/* src/jkv_pkg.sv */
// ----------------------------------------------------------------------------
// jkv_pkg
// shared types and constants of the json key/value extractor
// ----------------------------------------------------------------------------
`default_nettype none

package jkv_pkg;

   localparam int MAX_KEY_CHARS   = 16;
   localparam int MAX_HELD_SPACES = 63;
   localparam int WIN_LEN         = MAX_KEY_CHARS + 2;
   localparam int KEY_BITS        = 8 * MAX_KEY_CHARS;
   localparam int KLEN_W          = $clog2(MAX_KEY_CHARS + 1);
   localparam int KIDX_W          = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
   localparam int SUM_W           = $clog2(WIN_LEN + MAX_KEY_CHARS + 1);
   localparam int HOLD_CW         = $clog2(MAX_HELD_SPACES + 1);
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OC_OK        = 3'd0,
      OC_NO_KEY    = 3'd1,
      OC_NO_COLON  = 3'd2,
      OC_NO_VALUE  = 3'd3,
      OC_UNTERM    = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  value_char;
      logic        char_valid;
      logic        finished;
      outcome_type outcome;
   } rsp_type;

endpackage

`default_nettype wire

/* src/jkv_window_cell.sv */
// ----------------------------------------------------------------------------
// jkv_window_cell
// one byte of the key search window with its own pattern compare
// ----------------------------------------------------------------------------
`default_nettype none

module jkv_window_cell import jkv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       shift,
   input  wire logic       clear,
   input  wire logic [7:0] neighbour_byte,
   input  wire logic [7:0] expect_byte,
   input  wire logic       care,
   output logic [7:0]      byte_out,
   output logic            hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // the byte arriving from the neighbour is what this cell holds after the shift
   assign hit      = !care || (neighbour_byte == expect_byte);
   assign byte_out = byte_ff;

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = 8'h00;
      end else if (shift) begin
         byte_in = neighbour_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

endmodule

`default_nettype wire

/* src/jkv_hold_cell.sv */
// ----------------------------------------------------------------------------
// jkv_hold_cell
// one held white space character of a raw value, tab or space
// ----------------------------------------------------------------------------
`default_nettype none

module jkv_hold_cell import jkv_pkg::*; (
   input  wire logic clock,
   input  wire logic push,
   input  wire logic sel,
   input  wire logic push_tab,
   input  wire logic pop,
   input  wire logic next_in,
   output logic      is_tab
);

   logic tab_ff;
   logic tab_in;

   assign is_tab = tab_ff;

   // push writes the tail cell only, pop moves the whole row one place down
   always_comb begin
      tab_in = tab_ff;
      if (push && sel) begin
         tab_in = push_tab;
      end else if (pop) begin
         tab_in = next_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_ff <= tab_in;
   end

endmodule

`default_nettype wire

/* src/jkv_out_stage.sv */
// ----------------------------------------------------------------------------
// jkv_out_stage
// two-deep result buffer between the parser and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module jkv_out_stage import jkv_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take      = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

/* src/json_key_value_extractor.sv */
// ----------------------------------------------------------------------------
// json_key_value_extractor
// streams the value of one configured key out of a json body
// ----------------------------------------------------------------------------
// The block takes one body byte per clock and looks for the configured key
// in double quotes through a row of window cells that shift in every search
// byte and each compare their incoming byte. After the key it waits for a colon,
// skips white space and streams the value: a quoted value up to its closing
// quote, a raw value up to a comma, closing brace, CR, LF or the body end.
// Spaces and tabs inside a raw value are held in a row of hold cells and are
// only sent out once a further value character follows, so trailing white
// space is dropped; more than 63 held characters saturate. Every body ends
// with one result marked finished that carries the outcome; on an error
// outcome the characters already streamed are to be thrown away. A byte is
// taken every cycle except while held white space is flushed or results back
// up on rsp_stall: a value character that follows held characters keeps
// req_stall high while the hold row empties, one flushed result per held
// character and one for the value character itself.
// Results are registered before rsp_valid; a two-deep output buffer keeps
// the input open while a result waits on rsp_stall. The key registers
// are to be written through the csr port while the block is idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none

module json_key_value_extractor import jkv_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // body byte channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   // key configuration
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [5:0] {
      PH_SEARCH = 6'b000001,
      PH_COLON  = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_QUOTED = 6'b001000,
      PH_RAW    = 6'b010000,
      PH_FLUSH  = 6'b100000
   } phase_type;

   // key registers
   logic [CSR_DATA_W-1:0] key_lo_ff;
   logic [CSR_DATA_W-1:0] key_hi_ff;
   logic [KLEN_W-1:0]     key_len_ff;

   // parser state
   phase_type          phase_ff, phase_in;
   logic [HOLD_CW-1:0] count_ff, count_in;
   logic [7:0]         pend_char_ff, pend_char_in;
   logic               pend_end_ff, pend_end_in;

   // cell rows
   logic [7:0]               win_byte  [WIN_LEN];
   logic [7:0]               win_exp   [WIN_LEN];
   logic [WIN_LEN-1:0]       win_care;
   logic [WIN_LEN-1:0]       win_hit;
   logic [MAX_HELD_SPACES-1:0] hold_tab;
   logic [KEY_BITS-1:0]      key_all;
   logic [KLEN_W-1:0]        klen;
   logic                     key_hit;

   // control
   logic       accept;
   logic       out_full;
   logic       emit;
   rsp_type    emit_data;
   logic       body_rst;
   logic       win_shift;
   logic       hold_push;
   logic       hold_pop;
   logic       raw_go;
   logic [7:0] b;
   logic       b_end;
   logic       is_ws;
   logic       is_blank;
   logic       is_term;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff  <= '0;
         key_hi_ff  <= '0;
         key_len_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_lo_ff  <= csr_data;
            CSR_KEY_HIGH: key_hi_ff  <= csr_data;
            CSR_KEY_LEN:  key_len_ff <= csr_data[KLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // lengths above MAX_KEY_CHARS count as the full key
   assign klen    = (key_len_ff > KLEN_W'(MAX_KEY_CHARS)) ? KLEN_W'(MAX_KEY_CHARS)
                                                          : key_len_ff;
   assign key_all = KEY_BITS'({key_hi_ff, key_lo_ff});

   // ------------------------------------------------------------------------
   // search window: quote, key characters, quote, aligned to the newest end
   // ------------------------------------------------------------------------
   for (genvar j = 0; j < WIN_LEN; j++) begin : g_win
      logic [SUM_W-1:0]  pos_sum;
      logic [KIDX_W-1:0] kidx;
      logic              quote_here;
      logic [7:0]        neighbour;

      assign pos_sum     = SUM_W'(j) + SUM_W'(klen);
      assign win_care[j] = pos_sum >= SUM_W'(MAX_KEY_CHARS);
      assign quote_here  = (pos_sum == SUM_W'(MAX_KEY_CHARS)) || (j == WIN_LEN - 1);
      assign kidx        = KIDX_W'(pos_sum - SUM_W'(MAX_KEY_CHARS + 1));
      assign win_exp[j]  = quote_here ? CH_QUOTE : key_all[{kidx, 3'b000} +: 8];

      if (j == WIN_LEN - 1) begin : g_tail
         assign neighbour = b;
      end else begin : g_body
         assign neighbour = win_byte[j+1];
      end

      jkv_window_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift          (win_shift),
         .clear          (body_rst),
         .neighbour_byte (neighbour),
         .expect_byte    (win_exp[j]),
         .care           (win_care[j]),
         .byte_out       (win_byte[j]),
         .hit            (win_hit[j])
      );
   end

   assign key_hit = &win_hit;

   // ------------------------------------------------------------------------
   // hold row: held spaces and tabs of a raw value, oldest in cell 0
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < MAX_HELD_SPACES; i++) begin : g_hold
      logic next_tab;
      if (i == MAX_HELD_SPACES - 1) begin : g_last
         assign next_tab = 1'b0;
      end else begin : g_mid
         assign next_tab = hold_tab[i+1];
      end

      jkv_hold_cell u_cell (
         .clock    (clock),
         .push     (hold_push),
         .sel      (count_ff == HOLD_CW'(i)),
         .push_tab (b == CH_TAB),
         .pop      (hold_pop),
         .next_in  (next_tab),
         .is_tab   (hold_tab[i])
      );
   end

   // ------------------------------------------------------------------------
   // byte classes
   // ------------------------------------------------------------------------
   assign b        = req_data.body_byte;
   assign b_end    = req_data.body_end;
   assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
   assign is_ws    = is_blank || (b == CH_LF) || (b == CH_CR);
   assign is_term  = (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_LF) || (b == CH_CR);

   // input waits during a flush and while the output buffer is full
   assign req_stall = out_full || (phase_ff == PH_FLUSH);
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // parser
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      pend_char_in = pend_char_ff;
      pend_end_in  = pend_end_ff;
      emit         = 1'b0;
      emit_data    = '0;
      body_rst     = 1'b0;
      win_shift    = 1'b0;
      hold_push    = 1'b0;
      hold_pop     = 1'b0;
      raw_go       = 1'b0;

      if (phase_ff == PH_FLUSH) begin
         if (!out_full) begin
            emit                 = 1'b1;
            emit_data.char_valid = 1'b1;
            if (count_ff != '0) begin
               // oldest held character first
               emit_data.value_char = hold_tab[0] ? CH_TAB : CH_SPACE;
               hold_pop             = 1'b1;
               count_in             = count_ff - HOLD_CW'(1);
            end else begin
               emit_data.value_char = pend_char_ff;
               emit_data.finished   = pend_end_ff;
               emit_data.outcome    = OC_OK;
               if (pend_end_ff) begin
                  body_rst = 1'b1;
               end else begin
                  phase_in = PH_RAW;
               end
            end
         end
      end else if (accept) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               win_shift = 1'b1;
               if (key_hit) begin
                  phase_in = PH_COLON;
               end
               if (b_end) begin
                  emit               = 1'b1;
                  emit_data.finished = 1'b1;
                  emit_data.outcome  = key_hit ? OC_NO_COLON : OC_NO_KEY;
                  body_rst           = 1'b1;
               end
            end
            PH_COLON: begin
               if (b == CH_COLON) begin
                  phase_in = PH_SKIP;
               end
               if (b_end) begin
                  emit               = 1'b1;
                  emit_data.finished = 1'b1;
                  emit_data.outcome  = (b == CH_COLON) ? OC_NO_VALUE : OC_NO_COLON;
                  body_rst           = 1'b1;
               end
            end
            PH_SKIP: begin
               if (is_ws) begin
                  if (b_end) begin
                     emit               = 1'b1;
                     emit_data.finished = 1'b1;
                     emit_data.outcome  = OC_NO_VALUE;
                     body_rst           = 1'b1;
                  end
               end else if (b == CH_QUOTE) begin
                  phase_in = PH_QUOTED;
                  if (b_end) begin
                     emit               = 1'b1;
                     emit_data.finished = 1'b1;
                     emit_data.outcome  = OC_UNTERM;
                     body_rst           = 1'b1;
                  end
               end else begin
                  raw_go = 1'b1;
               end
            end
            PH_QUOTED: begin
               emit = 1'b1;
               if (b == CH_QUOTE) begin
                  emit_data.finished = 1'b1;
                  emit_data.outcome  = OC_OK;
                  body_rst           = 1'b1;
               end else begin
                  emit_data.value_char = b;
                  emit_data.char_valid = 1'b1;
                  if (b_end) begin
                     emit_data.finished = 1'b1;
                     emit_data.outcome  = OC_UNTERM;
                     body_rst           = 1'b1;
                  end
               end
            end
            PH_RAW: begin
               raw_go = 1'b1;
            end
            default: ;
         endcase

         // raw value byte, also the first one straight out of white space skip
         if (raw_go) begin
            phase_in = PH_RAW;
            if (is_term) begin
               emit               = 1'b1;
               emit_data.finished = 1'b1;
               emit_data.outcome  = OC_OK;
               body_rst           = 1'b1;
            end else if (is_blank) begin
               if (count_ff != HOLD_CW'(MAX_HELD_SPACES)) begin
                  hold_push = 1'b1;
                  count_in  = count_ff + HOLD_CW'(1);
               end
               if (b_end) begin
                  emit               = 1'b1;
                  emit_data.finished = 1'b1;
                  emit_data.outcome  = OC_OK;
                  body_rst           = 1'b1;
               end
            end else if (count_ff == '0) begin
               emit                 = 1'b1;
               emit_data.value_char = b;
               emit_data.char_valid = 1'b1;
               emit_data.finished   = b_end;
               emit_data.outcome    = OC_OK;
               body_rst             = b_end;
            end else begin
               // held white space goes out before this character
               phase_in     = PH_FLUSH;
               pend_char_in = b;
               pend_end_in  = b_end;
            end
         end
      end

      // end of a body result: back to a clean search
      if (body_rst) begin
         phase_in = PH_SEARCH;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      pend_char_ff <= pend_char_in;
      pend_end_ff  <= pend_end_in;
   end

   // ------------------------------------------------------------------------
   // result buffer
   // ------------------------------------------------------------------------
   jkv_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (emit_data),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a result that is not final carries no outcome
   a_outcome_only_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.finished |-> rsp_data.outcome == OC_OK)
      else $error("outcome set on a result that is not final");

   // the character field is clear unless it holds a character
   a_char_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |-> rsp_data.value_char == 8'h00)
      else $error("value_char set without char_valid");

   // held white space exists only inside a raw value
   a_hold_only_raw: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_RAW && phase_ff != PH_FLUSH |-> count_ff == '0)
      else $error("held characters outside a raw value");

   // a final result always leaves the parser searching again
   a_final_rearms: assert property (@(posedge clock) disable iff (reset)
      emit && emit_data.finished |=> phase_ff == PH_SEARCH && count_ff == '0)
      else $error("parser not rearmed after a final result");
`endif

endmodule

`default_nettype wire
